@@ design/piecewise_linear_curve_table_assert.svh @@
// assertion macros shared by the curve table modules
// no dependencies; included by the controller and the datapath
`ifndef PIECEWISE_LINEAR_CURVE_TABLE_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_TABLE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PLCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plct check failed");

// consequent must hold in the cycle after the antecedent
`define PLCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plct check failed");

`endif

@@ design/plct_pkg.sv @@
// shared types and constants for the piecewise linear curve table
// no dependencies
`default_nettype none

package plct_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_W         = 17;
  localparam int DIV_STEPS      = 16;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  // item kinds
  typedef enum logic [1:0] {
    KIND_WRITE     = 2'd0,
    KIND_SET_COUNT = 2'd1,
    KIND_DELETE    = 2'd2,
    KIND_EVAL      = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_REFUSED   = 2'd1,
    STAT_SATURATED = 2'd2
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_EV_FIRST,
    ST_EV_LAST_RD,
    ST_EV_LAST,
    ST_EV_SCAN_RD,
    ST_EV_SCAN,
    ST_DIV,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_SUM,
    ST_OUT
  } ctl_state_t;

  // datapath actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_WRITE,
    ACT_SET_COUNT,
    ACT_DEL_REFUSE,
    ACT_DEL_START,
    ACT_SHIFT,
    ACT_DEL_END,
    ACT_EMPTY,
    ACT_CLAMP,
    ACT_SEG_INIT,
    ACT_SEG_STEP,
    ACT_SEG_HIT,
    ACT_DIV_STEP,
    ACT_MUL_HI,
    ACT_MUL_LO
  } dp_act_t;

  // read address sources
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_LAST,
    RD_SCAN,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    dp_act_t act;
    rd_sel_t rd_sel;
    logic    sum;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  cnt_zero;
    logic  del_ok;
    logic  shift_more;
    logic  x_le_rd;
    logic  rd_le_x;
    logic  x_lt_rd;
    logic  scan_last;
    logic  div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/plct_in_if.sv @@
// input channel of the curve table: valid/ready plus the item word
// no dependencies
`default_nettype none

interface plct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] argument;
  logic [5:0]  write_index;
  logic [31:0] write_y;

  modport source (output valid, kind, argument, write_index, write_y, input ready);
  modport sink   (input valid, kind, argument, write_index, write_y, output ready);
endinterface

`default_nettype wire

@@ design/plct_out_if.sv @@
// result channel of the curve table: valid/ready plus the result word
// no dependencies
`default_nettype none

interface plct_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_result;
  logic [31:0] index_result;
  logic [1:0]  status;

  modport source (output valid, value_result, index_result, status, input ready);
  modport sink   (input valid, value_result, index_result, status, output ready);
endinterface

`default_nettype wire

@@ design/piecewise_linear_curve_table.sv @@
// write and set count: decoded, then the result is offered
// delete: a read and a write for each later point; evaluate: run time depends on the
// one-port segment scan (a read and a compare a point) and the 16-step divider
// one item at a time; the next item is taken once the result has been taken
// reset: point count cleared, point tables hold no value until written
`default_nettype none

module piecewise_linear_curve_table import plct_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  plct_in_if.sink   in_ch,
  plct_out_if.source out_ch
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  plct_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // table and arithmetic
  plct_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_ch.kind),
    .in_argument      (in_ch.argument),
    .in_write_index   (in_ch.write_index),
    .in_write_y       (in_ch.write_y),
    .out_value_result (out_ch.value_result),
    .out_index_result (out_ch.index_result),
    .out_status       (out_ch.status)
  );

endmodule

`default_nettype wire

@@ design/plct_ctl.sv @@
// controller state machine of the curve table
// depends on plct_pkg and the assertion macro header
`default_nettype none
`include "piecewise_linear_curve_table_assert.svh"

module plct_ctl import plct_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output ctl_cmd_t      cmd,
  input  wire dp_stat_t stat
);

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.act    = ACT_NONE;
    cmd.rd_sel = RD_ZERO;
    cmd.sum    = 1'b0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.act   = ACT_LOAD;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.kind)
          KIND_WRITE: begin
            cmd.act   = ACT_WRITE;
            state_nxt = ST_OUT;
          end
          KIND_SET_COUNT: begin
            cmd.act   = ACT_SET_COUNT;
            state_nxt = ST_OUT;
          end
          KIND_DELETE: begin
            if (stat.del_ok) begin
              cmd.act   = ACT_DEL_START;
              state_nxt = ST_SHIFT_RD;
            end else begin
              cmd.act   = ACT_DEL_REFUSE;
              state_nxt = ST_OUT;
            end
          end
          default: begin
            if (stat.cnt_zero) begin
              cmd.act   = ACT_EMPTY;
              state_nxt = ST_OUT;
            end else begin
              cmd.rd_sel = RD_ZERO;
              state_nxt  = ST_EV_FIRST;
            end
          end
        endcase
      end
      // delete: move each later point down one slot
      ST_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.rd_sel = RD_NEXT;
          state_nxt  = ST_SHIFT_WR;
        end else begin
          cmd.act   = ACT_DEL_END;
          state_nxt = ST_OUT;
        end
      end
      ST_SHIFT_WR: begin
        cmd.act   = ACT_SHIFT;
        state_nxt = ST_SHIFT_RD;
      end
      // evaluate: clamp against first and last point
      ST_EV_FIRST: begin
        if (stat.x_le_rd) begin
          cmd.act   = ACT_CLAMP;
          state_nxt = ST_OUT;
        end else begin
          cmd.act   = ACT_SEG_INIT;
          state_nxt = ST_EV_LAST_RD;
        end
      end
      ST_EV_LAST_RD: begin
        cmd.rd_sel = RD_LAST;
        state_nxt  = ST_EV_LAST;
      end
      ST_EV_LAST: begin
        if (stat.rd_le_x) begin
          cmd.act   = ACT_CLAMP;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_EV_SCAN_RD;
        end
      end
      // segment search
      ST_EV_SCAN_RD: begin
        cmd.rd_sel = RD_SCAN;
        state_nxt  = ST_EV_SCAN;
      end
      ST_EV_SCAN: begin
        if (stat.x_lt_rd || stat.scan_last) begin
          cmd.act   = ACT_SEG_HIT;
          state_nxt = ST_DIV;
        end else begin
          cmd.act   = ACT_SEG_STEP;
          state_nxt = ST_EV_SCAN_RD;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_MUL_HI;
        end else begin
          cmd.act = ACT_DIV_STEP;
        end
      end
      ST_MUL_HI: begin
        cmd.act   = ACT_MUL_HI;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.act   = ACT_MUL_LO;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `PLCT_ASSERT_NEXT(a_accept_decodes, clk, rst_n, in_valid && in_ready, state_r == ST_DECODE)
  `PLCT_ASSERT_NOW(a_shift_wr_after_rd, clk, rst_n, state_r == ST_SHIFT_WR, $past(state_r) == ST_SHIFT_RD)

endmodule

`default_nettype wire

@@ design/plct_dp.sv @@
// datapath of the curve table: point memories, count, search, divider and blend
// depends on plct_pkg and the assertion macro header
`default_nettype none
`include "piecewise_linear_curve_table_assert.svh"

module plct_dp import plct_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_cmd_t    cmd,
  output dp_stat_t         stat,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_argument,
  input  wire logic [5:0]  in_write_index,
  input  wire logic [31:0] in_write_y,
  output logic [31:0]      out_value_result,
  output logic [31:0]      out_index_result,
  output logic [1:0]       out_status
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  // captured item
  kind_t              kind_r;
  logic signed [31:0] arg_r;
  logic [5:0]         widx_r;
  logic [31:0]        wy_r;

  // table state
  logic [CNT_W-1:0]   count_r;
  logic [31:0]        mem_x [MAX_POINTS];
  logic [31:0]        mem_y [MAX_POINTS];
  logic signed [31:0] rd_x_r, rd_y_r;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [31:0]        wr_x, wr_y;
  logic               wr_en;

  // search and blend state
  logic [IDX_W-1:0]   k_r, i_r;
  logic signed [31:0] prev_x_r, prev_y_r, cur_y_r;
  logic [32:0]        span_r, rem_r;
  logic [FRAC_W-1:0]  f_r;
  logic [4:0]         div_cnt_r;
  logic signed [48:0] p_hi_r, p_lo_r;

  // results
  logic [31:0]        value_r, index_r;
  status_t            status_r;

  // decode helpers
  logic [31:0]        widx_ext;
  logic               widx_ok;
  logic signed [32:0] num, span;
  logic [33:0]        rem_sh;
  logic               rem_ge;
  logic signed [50:0] acc;
  logic signed [34:0] shifted;
  logic [31:0]        sat_val;
  logic [CNT_W-1:0]   last_cnt;

  assign widx_ext = {26'd0, widx_r};
  assign widx_ok  = widx_ext < 32'(MAX_POINTS);
  assign last_cnt = count_r - CNT_W'(1);

  // read address and write port selection
  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_LAST: rd_addr = IDX_W'(last_cnt);
      RD_SCAN: rd_addr = i_r;
      RD_NEXT: rd_addr = k_r + IDX_W'(1);
      default: rd_addr = '0;
    endcase
    if (cmd.act == ACT_SHIFT) begin
      wr_en   = 1'b1;
      wr_addr = k_r;
      wr_x    = rd_x_r;
      wr_y    = rd_y_r;
    end else begin
      wr_en   = (cmd.act == ACT_WRITE) && widx_ok;
      wr_addr = widx_ext[IDX_W-1:0];
      wr_x    = arg_r;
      wr_y    = wy_r;
    end
  end

  // point memories, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  // segment numerator, span and divider step
  assign num    = {arg_r[31], arg_r} - {prev_x_r[31], prev_x_r};
  assign span   = {rd_x_r[31], rd_x_r} - {prev_x_r[31], prev_x_r};
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, span_r};

  // rounded blend with saturation
  assign acc     = 51'(p_hi_r) + 51'(p_lo_r) + 51'sd32768;
  assign shifted = acc[50:16];
  always_comb begin
    if (shifted > 35'sd2147483647) begin
      sat_val = 32'h7fff_ffff;
    end else if (shifted < -35'sd2147483648) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = shifted[31:0];
    end
  end

  // point count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      case (cmd.act)
        ACT_SET_COUNT: begin
          if (arg_r > $signed(32'(MAX_POINTS))) begin
            count_r <= CNT_W'(MAX_POINTS);
          end else if (arg_r[31]) begin
            count_r <= '0;
          end else begin
            count_r <= arg_r[CNT_W-1:0];
          end
        end
        ACT_DEL_END: count_r <= last_cnt;
        default:     count_r <= count_r;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_LOAD: begin
        kind_r   <= kind_t'(in_kind);
        arg_r    <= in_argument;
        widx_r   <= in_write_index;
        wy_r     <= in_write_y;
        value_r  <= '0;
        index_r  <= '0;
        status_r <= STAT_DONE;
      end
      ACT_WRITE: begin
        status_r <= widx_ok ? STAT_DONE : STAT_REFUSED;
      end
      ACT_SET_COUNT: begin
        if (arg_r > $signed(32'(MAX_POINTS)) || arg_r[31]) begin
          status_r <= STAT_SATURATED;
        end
      end
      ACT_DEL_REFUSE: begin
        index_r  <= arg_r;
        status_r <= STAT_REFUSED;
      end
      ACT_DEL_START: begin
        k_r     <= arg_r[IDX_W-1:0];
        index_r <= (arg_r == 32'sd0) ? 32'd0 : arg_r - 32'sd1;
      end
      ACT_SHIFT: begin
        k_r <= k_r + IDX_W'(1);
      end
      ACT_EMPTY: begin
        status_r <= STAT_SATURATED;
      end
      ACT_CLAMP: begin
        value_r <= rd_y_r;
      end
      ACT_SEG_INIT, ACT_SEG_STEP: begin
        prev_x_r <= rd_x_r;
        prev_y_r <= rd_y_r;
        i_r      <= (cmd.act == ACT_SEG_INIT) ? IDX_W'(1) : i_r + IDX_W'(1);
      end
      ACT_SEG_HIT: begin
        cur_y_r   <= rd_y_r;
        span_r    <= span;
        rem_r     <= num;
        div_cnt_r <= '0;
        if (span <= 33'sd0) begin
          f_r <= FRAC_ONE;
        end else if (num <= 33'sd0) begin
          f_r <= '0;
        end else if (num >= span) begin
          f_r <= FRAC_ONE;
        end else begin
          f_r       <= '0;
          div_cnt_r <= 5'(DIV_STEPS);
        end
      end
      ACT_DIV_STEP: begin
        rem_r     <= rem_ge ? 33'(rem_sh - {1'b0, span_r}) : rem_sh[32:0];
        f_r       <= {f_r[FRAC_W-2:0], rem_ge};
        div_cnt_r <= div_cnt_r - 5'd1;
      end
      ACT_MUL_HI: begin
        p_hi_r <= 49'(cur_y_r * $signed({1'b0, f_r}));
      end
      ACT_MUL_LO: begin
        p_lo_r <= 49'(prev_y_r * $signed({1'b0, FRAC_ONE - f_r}));
      end
      default: begin
      end
    endcase
    if (cmd.sum) begin
      value_r <= sat_val;
    end
  end

  // status towards the controller
  always_comb begin
    stat.kind       = kind_r;
    stat.cnt_zero   = (count_r == '0);
    stat.del_ok     = (count_r >= CNT_W'(3)) && !arg_r[31]
                      && (arg_r < $signed(32'(count_r)));
    stat.shift_more = (CNT_W'(k_r) + CNT_W'(1)) < count_r;
    stat.x_le_rd    = arg_r <= rd_x_r;
    stat.rd_le_x    = rd_x_r <= arg_r;
    stat.x_lt_rd    = arg_r < rd_x_r;
    stat.scan_last  = CNT_W'(i_r) == last_cnt;
    stat.div_done   = (div_cnt_r == '0);
  end

  assign out_value_result = value_r;
  assign out_index_result = index_r;
  assign out_status       = status_r;

  `PLCT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, 32'(count_r) <= 32'(MAX_POINTS))
  `PLCT_ASSERT_NOW(a_div_live, clk, rst_n, cmd.act == ACT_DIV_STEP, div_cnt_r != 5'd0)

endmodule

`default_nettype wire
